[hdl/c8fd_pkg.sv]
// Shared types, codes and the CRC-8 update function of the frame deframer.
package c8fd_pkg;

   // CRC-8 constants: polynomial x^8 + x^2 + x + 1, zero start, MSB first.
   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] CRC_INIT = 8'h00;

   // Result kinds carried on the response channel.
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_OK      = 2'd1,
      KIND_BAD_CRC = 2'd2,
      KIND_TRUNC   = 2'd3
   } kind_type;

   // One received byte with its buffer-end marker.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_end;
   } item_type;

   // One result item.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] value_byte;
      logic [7:0] frame_length;
   } result_type;

   // Folds one byte into the running CRC, one polynomial step per bit.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[hdl/c8fd_req_if.sv]
// Request channel: one received byte per transfer.
interface c8fd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       buffer_end;

   modport source (output valid, output rx_byte, output buffer_end, input ready);
   modport sink (input valid, input rx_byte, input buffer_end, output ready);
endinterface

[hdl/c8fd_rsp_if.sv]
// Response channel: payload bytes and frame status results.
interface c8fd_rsp_if;
   logic                valid;
   logic                ready;
   c8fd_pkg::kind_type  kind;
   logic [7:0]          value_byte;
   logic [7:0]          frame_length;

   modport source (output valid, output kind, output value_byte, output frame_length,
                   input ready);
   modport sink (input valid, input kind, input value_byte, input frame_length,
                 output ready);
endinterface

[hdl/c8fd_in_stage.sv]
// Input register that holds one accepted byte until the parser consumes it.
module c8fd_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  c8fd_pkg::item_type  req_item,
   input  logic                advance,
   output logic                item_valid,
   output c8fd_pkg::item_type  item
);

   logic               valid_ff;
   logic               valid_in;
   c8fd_pkg::item_type item_ff;

   // A new byte may enter when the register is empty or drains this cycle.
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[hdl/c8fd_parser.sv]
// Frame parser: phase tracking, running CRC and result formation for one byte.
module c8fd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  c8fd_pkg::item_type    item,
   output logic                  res_valid,
   output c8fd_pkg::result_type  res
);

   typedef enum logic [1:0] {
      PH_TYPE    = 2'd0,
      PH_LEN     = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_CRC     = 2'd3
   } phase_type;

   phase_type  phase_ff,  phase_in;
   logic [7:0] type_ff,   type_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] left_ff,   left_in;
   logic [7:0] crc_ff,    crc_in;
   logic [7:0] left_dec;
   logic [7:0] crc_next;
   logic [7:0] crc_base;

   // One byte of CRC: restart from the initial value on a type byte.
   assign crc_base = (phase_ff == PH_TYPE) ? c8fd_pkg::CRC_INIT : crc_ff;
   assign crc_next = c8fd_pkg::crc8_update(crc_base, item.rx_byte);
   assign left_dec = left_ff - 8'd1;

   // Next state and result for the byte held in the input register.
   always_comb begin
      phase_in   = phase_ff;
      type_in    = type_ff;
      length_in  = length_ff;
      left_in    = left_ff;
      crc_in     = crc_ff;
      res_valid  = 1'b0;
      res        = '{kind: c8fd_pkg::KIND_PAYLOAD, value_byte: item.rx_byte,
                     frame_length: 8'd0};

      unique case (phase_ff)
         PH_TYPE: begin
            type_in   = item.rx_byte;
            length_in = 8'd0;
            crc_in    = crc_next;
            phase_in  = PH_LEN;
         end
         PH_LEN: begin
            length_in = item.rx_byte;
            left_in   = item.rx_byte;
            crc_in    = crc_next;
            phase_in  = (item.rx_byte != 8'd0) ? PH_PAYLOAD : PH_CRC;
         end
         PH_PAYLOAD: begin
            crc_in  = crc_next;
            left_in = left_dec;
            if (left_dec == 8'd0) begin
               phase_in = PH_CRC;
            end
            res_valid = !item.buffer_end;
         end
         PH_CRC: begin
            res_valid = 1'b1;
            res.kind  = (item.rx_byte == crc_ff) ? c8fd_pkg::KIND_OK
                                                 : c8fd_pkg::KIND_BAD_CRC;
            res.value_byte   = type_ff;
            res.frame_length = length_ff;
         end
         default: begin
            phase_in = PH_TYPE;
         end
      endcase

      // A buffer end before the CRC byte reports a truncated frame.
      if (item.buffer_end && (phase_ff != PH_CRC)) begin
         res_valid        = 1'b1;
         res.kind         = c8fd_pkg::KIND_TRUNC;
         res.value_byte   = type_in;
         res.frame_length = length_in;
      end

      // Any status returns the parser to its cleared state.
      if (item.buffer_end || (phase_ff == PH_CRC)) begin
         phase_in  = PH_TYPE;
         type_in   = 8'd0;
         length_in = 8'd0;
         left_in   = 8'd0;
         crc_in    = c8fd_pkg::CRC_INIT;
      end
   end

   // Parser state advances only when the held byte is consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TYPE;
         type_ff   <= 8'd0;
         length_ff <= 8'd0;
         left_ff   <= 8'd0;
         crc_ff    <= c8fd_pkg::CRC_INIT;
      end else if (advance) begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         length_ff <= length_in;
         left_ff   <= left_in;
         crc_ff    <= crc_in;
      end
   end

endmodule

[hdl/c8fd_out_stage.sv]
// Result register that presents one result until the response transfer.
module c8fd_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  c8fd_pkg::result_type  res,
   output logic                  can_load,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output c8fd_pkg::result_type  rsp_res
);

   logic                 valid_ff;
   logic                 valid_in;
   c8fd_pkg::result_type res_ff;

   // The register takes a new result when empty or being drained.
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

endmodule

[hdl/crc8_frame_deframer.sv]
// Top level of the CRC-8 type-length-payload frame deframer.
//
// The deframer takes one received byte per transfer and parses frames of a
// type byte, a length byte, that many payload bytes and a CRC-8 byte
// (polynomial 0x07, zero start, MSB first, over type, length and payload).
// Every payload byte comes out as a kind 0 result unless it carries the
// buffer-end marker; the CRC byte yields an accepted or mismatch status with
// the type and length, and a buffer-end marker before the CRC byte yields a
// truncated status and restarts parsing. A byte is accepted in every cycle
// while results are taken. Each byte is held in the input register until it
// moves on, and its result is then loaded into the result register, from
// which it is offered on the response channel. The input stalls only when a
// byte that produces a result finds the result register full and not
// draining. The rate is set by the combinational CRC byte update between the
// input and result registers.
module crc8_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   c8fd_req_if.sink    req_if,
   c8fd_rsp_if.source  rsp_if
);

   c8fd_pkg::item_type   req_item;
   c8fd_pkg::item_type   item;
   c8fd_pkg::result_type res;
   c8fd_pkg::result_type rsp_res;
   logic                 item_valid;
   logic                 res_valid;
   logic                 can_load;
   logic                 advance;

   assign req_item = '{rx_byte: req_if.rx_byte, buffer_end: req_if.buffer_end};

   // The held byte moves on unless its result would find the output full.
   assign advance = item_valid && (!res_valid || can_load);

   c8fd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   c8fd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   c8fd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && res_valid),
      .res       (res),
      .can_load  (can_load),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_res   (rsp_res)
   );

   assign rsp_if.kind         = rsp_res.kind;
   assign rsp_if.value_byte   = rsp_res.value_byte;
   assign rsp_if.frame_length = rsp_res.frame_length;

endmodule

[hdl/c8fd_checker.sv]
// Port-level checks of the frame deframer and their attachment to the top level.
module c8fd_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input c8fd_pkg::kind_type  rsp_kind,
   input logic [7:0]          rsp_value_byte,
   input logic [7:0]          rsp_frame_length
);

   // A stalled result holds still until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_value_byte) && $stable(rsp_frame_length))
      else $error("rsp payload changed while stalled");

   // Payload results carry no length.
   a_payload_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == c8fd_pkg::KIND_PAYLOAD) |-> rsp_frame_length == 8'd0)
      else $error("payload result with nonzero length");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A fresh result is checked against a request transfer in an earlier cycle.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without a matching request transfer");

endmodule

bind crc8_frame_deframer c8fd_checker u_c8fd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_kind         (rsp_if.kind),
   .rsp_value_byte   (rsp_if.value_byte),
   .rsp_frame_length (rsp_if.frame_length)
);
